// ===== hdl/spq_pkg.sv =====
// Shared types, codes and helper functions for the sorted priority queue.
// Used by every module of the block; depends on nothing.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;

   typedef logic [1:0] spq_op_type;
   localparam spq_op_type OP_PUSH   = 2'd0;
   localparam spq_op_type OP_POP    = 2'd1;
   localparam spq_op_type OP_TOP    = 2'd2;
   localparam spq_op_type OP_CHANGE = 2'd3;

   typedef logic [1:0] spq_status_type;
   localparam spq_status_type STATUS_OK        = 2'd0;
   localparam spq_status_type STATUS_EMPTY     = 2'd1;
   localparam spq_status_type STATUS_NOT_FOUND = 2'd2;
   localparam spq_status_type STATUS_FULL      = 2'd3;

   typedef logic [1:0] spq_rel_type;
   localparam spq_rel_type REL_LE = 2'd0;
   localparam spq_rel_type REL_GE = 2'd1;
   localparam spq_rel_type REL_LT = 2'd2;
   localparam spq_rel_type REL_GT = 2'd3;

   typedef logic [1:0] spq_sel_type;
   localparam spq_sel_type SEL_KEEP  = 2'd0;
   localparam spq_sel_type SEL_LEFT  = 2'd1;
   localparam spq_sel_type SEL_RIGHT = 2'd2;
   localparam spq_sel_type SEL_NEW   = 2'd3;

   typedef logic [CAPACITY-1:0] spq_vec_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] elem;
      logic signed [DATA_W-1:0] pri;
   } spq_entry_type;

   typedef struct packed {
      logic match;
      logic fwd;
      logic bwd;
   } spq_flags_type;

   typedef struct packed {
      spq_status_type status;
      logic           front_ok;
      spq_vec_type    next_valid;
   } spq_plan_type;

   function automatic logic spq_rel(input spq_rel_type r,
                                    input logic signed [DATA_W-1:0] a,
                                    input logic signed [DATA_W-1:0] b);
      logic res;
      case (r)
         REL_LE:  res = (a <= b);
         REL_GE:  res = (a >= b);
         REL_LT:  res = (a < b);
         REL_GT:  res = (a > b);
         default: res = 1'b0;
      endcase
      return res;
   endfunction

   // Bit i of the result is the OR of bits 0 through i.
   function automatic spq_vec_type spq_prefix_or(input spq_vec_type x);
      spq_vec_type acc;
      int s;
      acc = x;
      for (s = 1; s < CAPACITY; s = s * 2) begin
         acc = acc | (acc << s);
      end
      return acc;
   endfunction

   // Bit i of the result is the OR of bits i through the top.
   function automatic spq_vec_type spq_suffix_or(input spq_vec_type x);
      spq_vec_type acc;
      int s;
      acc = x;
      for (s = 1; s < CAPACITY; s = s * 2) begin
         acc = acc | (acc >> s);
      end
      return acc;
   endfunction

endpackage

// ===== hdl/spq_cell.sv =====
// One storage cell of the queue: an entry, its compare flags and its neighbor mux.
// Depends on spq_pkg.
module spq_cell (
   input  logic                  clock,
   input  logic                  load_flags,
   input  spq_pkg::spq_rel_type  relation,
   input  spq_pkg::spq_entry_type cmp_word,
   input  logic                  cell_valid,
   output spq_pkg::spq_flags_type flags,
   input  logic                  update,
   input  spq_pkg::spq_sel_type  sel,
   input  spq_pkg::spq_entry_type left_entry,
   input  spq_pkg::spq_entry_type right_entry,
   input  spq_pkg::spq_entry_type fresh_entry,
   output spq_pkg::spq_entry_type entry
);
   import spq_pkg::*;

   spq_entry_type entry_ff;
   spq_entry_type entry_in;
   spq_flags_type flags_ff;
   spq_flags_type flags_in;

   always_comb begin
      flags_in.match = cell_valid && (entry_ff.elem == cmp_word.elem);
      flags_in.fwd   = spq_rel(relation, cmp_word.pri, entry_ff.pri);
      flags_in.bwd   = spq_rel(relation, entry_ff.pri, cmp_word.pri);
   end

   always_comb begin
      case (sel)
         SEL_KEEP:  entry_in = entry_ff;
         SEL_LEFT:  entry_in = left_entry;
         SEL_RIGHT: entry_in = right_entry;
         SEL_NEW:   entry_in = fresh_entry;
         default:   entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_flags) begin
         flags_ff <= flags_in;
      end
      if (update) begin
         entry_ff <= entry_in;
      end
   end

   assign flags = flags_ff;
   assign entry = entry_ff;

endmodule

// ===== hdl/spq_plan.sv =====
// Turns the registered cell flags and the opcode into a per-cell move plan.
// Depends on spq_pkg.
module spq_plan (
   input  spq_pkg::spq_op_type                         opcode,
   input  spq_pkg::spq_vec_type                        valid,
   input  spq_pkg::spq_flags_type [spq_pkg::CAPACITY-1:0] flags,
   output spq_pkg::spq_sel_type   [spq_pkg::CAPACITY-1:0] cell_sel,
   output spq_pkg::spq_plan_type                       plan
);
   import spq_pkg::*;

   spq_vec_type match_v, fwd_v, bwd_v, vext;
   spq_vec_type push_w, push_lo;
   spq_vec_type m_incl, hit, below, above;
   spq_vec_type up_stop, up_w, up_lo, dn_stop, dn_w, dn_hi;
   logic        found, move_up, move_down;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_v[i] = flags[i].match;
         fwd_v[i]   = flags[i].fwd;
         bwd_v[i]   = flags[i].bwd;
      end
      vext    = {valid[CAPACITY-2:0], 1'b1};
      push_w  = spq_prefix_or((fwd_v & valid) | ~valid) & vext;
      push_lo = push_w & ~(push_w << 1);

      m_incl    = spq_prefix_or(match_v);
      hit       = m_incl & ~(m_incl << 1);
      below     = ~m_incl;
      above     = m_incl & ~hit;
      found     = |match_v;
      move_up   = |(hit & fwd_v);
      move_down = !move_up && (|(hit & bwd_v));

      up_stop = spq_suffix_or(below & ~fwd_v);
      up_w    = (below & ~up_stop) | hit;
      up_lo   = up_w & ~(up_w << 1);
      dn_stop = spq_prefix_or(above & valid & ~bwd_v);
      dn_w    = (above & valid & ~dn_stop) | hit;
      dn_hi   = dn_w & ~(dn_w >> 1);
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_sel[i] = SEL_KEEP;
      end
      plan.status     = STATUS_OK;
      plan.front_ok   = 1'b0;
      plan.next_valid = valid;
      case (opcode)
         OP_PUSH: begin
            if (valid[CAPACITY-1]) begin
               plan.status = STATUS_FULL;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  cell_sel[i] = push_lo[i] ? SEL_NEW : (push_w[i] ? SEL_LEFT : SEL_KEEP);
               end
               plan.next_valid = vext;
            end
         end
         OP_POP: begin
            if (!valid[0]) begin
               plan.status = STATUS_EMPTY;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  cell_sel[i] = valid[i] ? SEL_RIGHT : SEL_KEEP;
               end
               plan.next_valid = valid >> 1;
               plan.front_ok   = 1'b1;
            end
         end
         OP_TOP: begin
            if (!valid[0]) begin
               plan.status = STATUS_EMPTY;
            end else begin
               plan.front_ok = 1'b1;
            end
         end
         OP_CHANGE: begin
            if (!found) begin
               plan.status = STATUS_NOT_FOUND;
            end else if (move_up) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  cell_sel[i] = up_lo[i] ? SEL_NEW : (up_w[i] ? SEL_LEFT : SEL_KEEP);
               end
            end else if (move_down) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  cell_sel[i] = dn_hi[i] ? SEL_NEW : (dn_w[i] ? SEL_RIGHT : SEL_KEEP);
               end
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  cell_sel[i] = hit[i] ? SEL_NEW : SEL_KEEP;
               end
            end
         end
         default: begin
            plan.status = STATUS_OK;
         end
      endcase
   end

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
// Sorted priority queue built as a row of entry cells with a shared move planner.
// Depends on spq_pkg, spq_cell and spq_plan.
//
// Usage:
// The request channel (req_valid/req_ready) carries one word per operation:
// push, pop, top or change priority, with an element and a priority. The
// response channel (rsp_valid/rsp_ready) returns one word per request with
// the front entry for a pop or top, a status code and an empty flag.
// Every cell compares the request against its entry in the cycle the word
// is accepted; in the apply state, once the response register is free, the
// planner resolves the first match or insertion point across the row and
// every cell loads itself, its left or right neighbor, or the new entry.
// The response is registered at that commit, and no new word is taken until
// then; the two-step compare and shift of the cell row sets this limit.
// csr_write_enable writes the ordering relation, to be changed only while
// the queue is idle.
// Synchronous reset empties the queue, selects the less-or-equal relation
// and drops any pending response. While the receiver stalls, the finished
// response stays in its register and the next operation waits in its
// commit cycle, holding req_ready low.
module sorted_priority_queue_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic signed [31:0]            req_element_value,
   input  logic signed [31:0]            req_priority_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [31:0]            rsp_out_element,
   output logic signed [31:0]            rsp_out_priority,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_is_empty,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_write_data
);
   import spq_pkg::*;

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_APPLY = 1'b1;

   logic           state_ff, state_in;
   spq_rel_type    relation_ff;
   spq_op_type     opcode_ff;
   spq_entry_type  fresh_ff;
   spq_entry_type  cmp_word;
   spq_vec_type    valid_ff;
   logic           accept, commit;

   logic                  rsp_valid_ff;
   logic signed [31:0]    rsp_element_ff, rsp_priority_ff;
   spq_status_type        rsp_status_ff;
   logic                  rsp_empty_ff;

   spq_entry_type [CAPACITY-1:0] cell_data;
   spq_entry_type [CAPACITY-1:0] left_data;
   spq_entry_type [CAPACITY-1:0] right_data;
   spq_flags_type [CAPACITY-1:0] cell_flags;
   spq_sel_type   [CAPACITY-1:0] cell_sel;
   spq_plan_type                 plan;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign commit    = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_ready);

   assign cmp_word.elem = req_element_value;
   assign cmp_word.pri  = req_priority_value;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_APPLY;
         ST_APPLY: if (commit) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         relation_ff  <= REL_LE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            relation_ff <= csr_write_data;
         end
         if (commit) begin
            valid_ff     <= plan.next_valid;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff <= req_opcode;
         fresh_ff  <= cmp_word;
      end
      if (commit) begin
         rsp_element_ff  <= plan.front_ok ? cell_data[0].elem : '0;
         rsp_priority_ff <= plan.front_ok ? cell_data[0].pri : '0;
         rsp_status_ff   <= plan.status;
         rsp_empty_ff    <= !plan.next_valid[0];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_left_edge
         assign left_data[i] = cell_data[i];
      end else begin : g_left_inner
         assign left_data[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_right_edge
         assign right_data[i] = cell_data[i];
      end else begin : g_right_inner
         assign right_data[i] = cell_data[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .load_flags  (accept),
         .relation    (relation_ff),
         .cmp_word    (cmp_word),
         .cell_valid  (valid_ff[i]),
         .flags       (cell_flags[i]),
         .update      (commit),
         .sel         (cell_sel[i]),
         .left_entry  (left_data[i]),
         .right_entry (right_data[i]),
         .fresh_entry (fresh_ff),
         .entry       (cell_data[i])
      );
   end

   spq_plan u_plan (
      .opcode   (opcode_ff),
      .valid    (valid_ff),
      .flags    (cell_flags),
      .cell_sel (cell_sel),
      .plan     (plan)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_element  = rsp_element_ff;
   assign rsp_out_priority = rsp_priority_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

// ===== hdl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue_top.
module spq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_out_element,
   input logic signed [31:0] rsp_out_priority,
   input logic [1:0]         rsp_status,
   input logic               rsp_is_empty
);
   import spq_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another word is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_out_element)
         && $stable(rsp_out_priority) && $stable(rsp_status) && $stable(rsp_is_empty)))
      else $error("stalled response word changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_EMPTY) |->
         (rsp_out_element == 0 && rsp_out_priority == 0 && rsp_is_empty))
      else $error("empty status with front data or non-empty flag");

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_FULL) |->
         (!rsp_is_empty && rsp_out_element == 0 && rsp_out_priority == 0))
      else $error("full status with empty flag or front data");

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_element  (rsp_out_element),
   .rsp_out_priority (rsp_out_priority),
   .rsp_status       (rsp_status),
   .rsp_is_empty     (rsp_is_empty)
);
